@@ rtl/core/kti_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe track interpolator package
// Shared types, operation codes and constants.
// ---------------------------------------------------------------------------
package kti_pkg;

   localparam int MaxKeysDefault = 64;
   localparam logic [31:0] OneQ16 = 32'h0001_0000;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRAP,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_CHECK,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [6:0]  count;
   } div_ctl_type;

endpackage

@@ rtl/core/kti_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe track interpolator channels
// Valid/ready interfaces for the request and response channels.
// ---------------------------------------------------------------------------
interface kti_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] key_time;
   logic [31:0] key_value;
   logic [31:0] query_time;
   modport source (output valid, operation, key_time, key_value, query_time, input ready);
   modport sink   (input valid, operation, key_time, key_value, query_time, output ready);
endinterface

interface kti_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_value;
   logic        status;
   modport source (output valid, sample_value, status, input ready);
   modport sink   (input valid, sample_value, status, output ready);
endinterface

@@ rtl/core/kti_divider.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Keyframe track interpolator shared divider
// Restoring shift/subtract unit, one quotient bit per cycle, shared between
// the loop wrap (32-bit) and the interpolation weight (66-bit dividend).
// ---------------------------------------------------------------------------
module kti_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  kti_pkg::div_ctl_type    ctl,
   input  logic [65:0]             dividend,
   input  logic [32:0]             divisor,
   output logic                    busy,
   output logic [65:0]             quotient,
   output logic [32:0]             remainder
);
   import kti_pkg::*;

   logic [65:0] num_ff, num_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [33:0] shifted;
   logic [33:0] diff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      shifted = {rem_ff[32:0], num_ff[65]};
      diff    = shifted - {1'b0, den_ff};
      if (ctl.start) begin
         num_in = dividend << (7'd66 - (ctl.count + 7'd1));
         rem_in = '0;
         den_in = divisor;
         cnt_in = ctl.count + 7'd1;
      end else if (cnt_ff != 7'd0) begin
         if (!diff[33]) begin
            rem_in = diff;
            num_in = {num_ff[64:0], 1'b1};
         end else begin
            rem_in = shifted;
            num_in = {num_ff[64:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy      = (cnt_ff != 7'd0);
   assign quotient  = num_ff;
   assign remainder = rem_ff[32:0];
endmodule

@@ rtl/core/keyframe_track_interpolator.sv @@
`timescale 1ns / 1ps
// Clear and append go straight to ST_DONE; sample wraps the query time in the
// shared divider, scans keys from the front, then divides the interpolation
// weight in the shared divider. One item in flight; the next transfer can
// be taken in the cycle the response is raised, if rsp.ready is high.
// Synchronous active-high reset empties the track and zeroes the loop duration;
// key memories are not cleared.
// ---------------------------------------------------------------------------
// Keyframe track interpolator
// Scalar Q16.16 key track: clear, append, wrapped linear sampling.
// ---------------------------------------------------------------------------
module keyframe_track_interpolator #(
   parameter int MAX_KEYS = kti_pkg::MaxKeysDefault
) (
   input  logic        clock,
   input  logic        reset,
   kti_req_if.sink     req,
   kti_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [30:0] csr_write_data
);
   import kti_pkg::*;

   localparam int IW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);

   logic [31:0] time_mem  [MAX_KEYS];
   logic [31:0] value_mem [MAX_KEYS];

   state_type   state_ff, state_in;
   logic [30:0] loop_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] t_ff, t_in;
   logic [IW-1:0] hi_ff, hi_in, rd_addr;
   logic [31:0] rd_time_ff, rd_value_ff;
   logic [31:0] tlo_ff, tlo_in, vlo_ff, vlo_in, thi_ff, thi_in, vhi_ff, vhi_in;
   logic [31:0] out_ff, out_in;
   logic        status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        neg_ff, neg_in;
   logic [32:0] mag_ff, mag_in, dt_ff, dt_in, span_ff, span_in;
   logic [65:0] prod_ff, prod_in;
   logic        wr_en;
   div_ctl_type div_ctl;
   logic [65:0] div_num;
   logic [32:0] div_den;
   logic        div_busy;
   logic [65:0] div_q;
   logic [32:0] div_r;
   logic [32:0] q_round;

   kti_divider u_div (
      .clock(clock), .reset(reset), .ctl(div_ctl), .dividend(div_num),
      .divisor(div_den), .busy(div_busy), .quotient(div_q), .remainder(div_r)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[count_ff[IW-1:0]]  <= req.key_time;
         value_mem[count_ff[IW-1:0]] <= req.key_value;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      t_in         = t_ff;
      hi_in        = hi_ff;
      tlo_in       = tlo_ff;
      vlo_in       = vlo_ff;
      thi_in       = thi_ff;
      vhi_in       = vhi_ff;
      out_in       = out_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      dt_in        = dt_ff;
      span_in      = span_ff;
      prod_in      = prod_ff;
      wr_en        = 1'b0;
      rd_addr      = '0;
      div_ctl      = '0;
      div_num      = {34'd0, t_ff};
      div_den      = {2'b0, loop_ff};
      req.ready    = 1'b0;
      q_round      = div_q[32:0] + {32'd0, ({div_r, 1'b0} >= {1'b0, span_ff})};
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = !rsp_valid_ff || rsp.ready;
            if (req.valid && req.ready) begin
               out_in    = '0;
               status_in = 1'b0;
               t_in      = req.query_time;
               unique case (op_type'(req.operation))
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  OP_APPEND: begin
                     if (count_ff >= CW'(MAX_KEYS)) begin
                        status_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                     state_in = ST_DONE;
                  end
                  OP_SAMPLE: begin
                     if (loop_ff != '0 && !req.query_time[31] && req.query_time != '0) begin
                        div_ctl.start = 1'b1;
                        div_ctl.count = 7'd31;
                        div_num = {34'd0, req.query_time};
                        state_in = ST_WRAP;
                     end else begin
                        state_in = ST_RD_FIRST;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_WRAP: begin
            if (!div_busy) begin
               t_in     = div_r[31:0];
               state_in = ST_RD_FIRST;
            end
         end
         ST_RD_FIRST: begin
            rd_addr  = '0;
            state_in = ST_RD_LAST;
         end
         ST_RD_LAST: begin
            rd_addr = IW'(count_ff - CW'(1));
            tlo_in  = rd_time_ff;
            vlo_in  = rd_value_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            thi_in = rd_time_ff;
            vhi_in = rd_value_ff;
            hi_in  = IW'(1);
            if (count_ff == '0) begin
               out_in   = OneQ16;
               state_in = ST_DONE;
            end else if (count_ff == CW'(1) || $signed(t_ff) <= $signed(tlo_ff)) begin
               out_in   = vlo_ff;
               state_in = ST_DONE;
            end else if ($signed(t_ff) >= $signed(rd_time_ff)) begin
               out_in   = rd_value_ff;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            rd_addr  = hi_ff;
            state_in = ST_SEARCH_WAIT;
         end
         ST_SEARCH_WAIT: begin
            if (hi_ff != IW'(count_ff - CW'(1)) && $signed(rd_time_ff) < $signed(t_ff)) begin
               tlo_in   = rd_time_ff;
               vlo_in   = rd_value_ff;
               hi_in    = hi_ff + IW'(1);
               state_in = ST_SEARCH;
            end else begin
               thi_in   = rd_time_ff;
               vhi_in   = rd_value_ff;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            mag_in  = 33'($signed(vhi_ff) - $signed(vlo_ff));
            neg_in  = mag_in[32];
            if (mag_in[32]) begin
               mag_in = 33'd0 - mag_in;
            end
            dt_in   = 33'($signed(t_ff) - $signed(tlo_ff));
            span_in = 33'($signed(thi_ff) - $signed(tlo_ff));
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = mag_ff * dt_ff;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) begin
               div_ctl.start = 1'b1;
               div_ctl.count = 7'd65;
               div_num  = prod_ff;
               div_den  = span_ff;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            div_num = prod_ff;
            div_den = span_ff;
            if (!div_busy) begin
               out_in   = neg_ff ? vlo_ff - q_round[31:0] : vlo_ff + q_round[31:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      hi_ff   <= hi_in;
      tlo_ff  <= tlo_in;
      vlo_ff  <= vlo_in;
      thi_ff  <= thi_in;
      vhi_ff  <= vhi_in;
      out_ff  <= out_in;
      status_ff <= status_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      dt_ff   <= dt_in;
      span_ff <= span_in;
      prod_ff <= prod_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         loop_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            loop_ff <= csr_write_data;
         end
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample_value = out_ff;
   assign rsp.status       = status_ff;
endmodule
